### hw/rtl/mck_pkg.sv
package mck_pkg;

    localparam int TICK_W      = 24;
    localparam int CODE_W      = 8;
    localparam int MAX_ELEMS   = 5;
    localparam int ELEM_IDX_W  = 3;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
    localparam int APB_AW      = 5;
    localparam int APB_DW      = 32;
    localparam int M_TDATA_W   = 32;

    // register indexes (byte address = 4 * index)
    localparam logic [2:0] REG_DOT       = 3'd0;
    localparam logic [2:0] REG_DASH      = 3'd1;
    localparam logic [2:0] REG_ELEM_GAP  = 3'd2;
    localparam logic [2:0] REG_CHAR_GAP  = 3'd3;
    localparam logic [2:0] REG_WORD_GAP  = 3'd4;

    localparam logic [TICK_W-1:0] DOT_RST       = 24'd300000;
    localparam logic [TICK_W-1:0] DASH_RST      = 24'd900000;
    localparam logic [TICK_W-1:0] ELEM_GAP_RST  = 24'd300000;
    localparam logic [TICK_W-1:0] CHAR_GAP_RST  = 24'd900000;
    localparam logic [TICK_W-1:0] WORD_GAP_RST  = 24'd2100000;

    typedef struct packed {
        logic [TICK_W-1:0] dot;
        logic [TICK_W-1:0] dash;
        logic [TICK_W-1:0] elem_gap;
        logic [TICK_W-1:0] char_gap;
        logic [TICK_W-1:0] word_gap;
    } cfg_t;

    // one classified character; shape bit i is element i, 1 = dash
    typedef struct packed {
        logic                  unknown;
        logic                  word_end;
        logic [ELEM_IDX_W-1:0] count;
        logic [MAX_ELEMS-1:0]  shape;
    } desc_t;

    function automatic desc_t classify(input logic [CODE_W-1:0] code,
                                       input logic word_end);
        desc_t d;
        d.unknown  = 1'b0;
        d.word_end = word_end;
        d.count    = 3'd0;
        d.shape    = 5'b00000;
        unique case (code)
            "E": begin d.count = 3'd1; d.shape = 5'b00000; end
            "H": begin d.count = 3'd4; d.shape = 5'b00000; end
            "L": begin d.count = 3'd4; d.shape = 5'b00010; end
            "O": begin d.count = 3'd3; d.shape = 5'b00111; end
            "S": begin d.count = 3'd3; d.shape = 5'b00000; end
            "T": begin d.count = 3'd1; d.shape = 5'b00001; end
            "W": begin d.count = 3'd3; d.shape = 5'b00110; end
            "0": begin d.count = 3'd5; d.shape = 5'b11111; end
            "1": begin d.count = 3'd5; d.shape = 5'b11110; end
            "2": begin d.count = 3'd5; d.shape = 5'b11100; end
            "6": begin d.count = 3'd5; d.shape = 5'b00001; end
            default: begin
                d.unknown  = 1'b1;
                d.word_end = 1'b0;
            end
        endcase
        return d;
    endfunction

endpackage

### hw/rtl/morse_code_keyer_timing.sv
// Morse keyer timing. Each input transfer carries one ASCII character (tdata)
// and an end-of-word flag (tlast); the block answers with the character's
// keying as timed LED segments, one output transfer per segment: a mark of
// dot or dash length for each element, then a gap of element_gap_ticks, the
// final gap being char_gap_ticks, or word_gap_ticks when the word ends there
// (taken as the whole off time). tlast marks the final segment of a
// character. Only E H L O S T W 0 1 2 6 are encoded; any other code yields a
// single zero-length off segment with tuser (unknown) and tlast set.
// Rate: an encoded character of n elements occupies the output for 2n
// segments (2 to 10), an unknown one a single segment; the segment sequencer
// emits one per cycle unless m_tready stalls it. Inputs are taken one
// per cycle until the two-entry descriptor queue and the sequencer's current
// character are occupied. Timing registers sit on an APB port at byte
// addresses 0x00..0x10 and should only be written while the block is idle.
module morse_code_keyer_timing (
    input  logic                          aclk,
    input  logic                          aresetn,
    // input channel
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [mck_pkg::CODE_W-1:0]    s_tdata,   // [7:0] char_code
    input  logic                          s_tlast,   // word_end
    // segment channel
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [mck_pkg::M_TDATA_W-1:0] m_tdata,   // [0] led_on, [24:1] duration
    output logic                          m_tlast,   // last segment of character
    output logic                          m_tuser,   // [0] unknown
    // configuration
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [mck_pkg::APB_AW-1:0]    paddr,
    input  logic [mck_pkg::APB_DW-1:0]    pwdata,
    output logic [mck_pkg::APB_DW-1:0]    prdata,
    output logic                          pready
);

    mck_pkg::cfg_t   cfg_reg;
    logic            cfg_wr;
    logic [2:0]      reg_idx;

    logic            q_full, q_wr, q_rd, q_valid;
    mck_pkg::desc_t  q_wdata, q_rdata;

    // ---- configuration registers ----
    assign pready  = 1'b1;
    assign reg_idx = paddr[4:2];
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.dot      <= mck_pkg::DOT_RST;
            cfg_reg.dash     <= mck_pkg::DASH_RST;
            cfg_reg.elem_gap <= mck_pkg::ELEM_GAP_RST;
            cfg_reg.char_gap <= mck_pkg::CHAR_GAP_RST;
            cfg_reg.word_gap <= mck_pkg::WORD_GAP_RST;
        end else if (cfg_wr) begin
            case (reg_idx)
                mck_pkg::REG_DOT:      cfg_reg.dot      <= pwdata[mck_pkg::TICK_W-1:0];
                mck_pkg::REG_DASH:     cfg_reg.dash     <= pwdata[mck_pkg::TICK_W-1:0];
                mck_pkg::REG_ELEM_GAP: cfg_reg.elem_gap <= pwdata[mck_pkg::TICK_W-1:0];
                mck_pkg::REG_CHAR_GAP: cfg_reg.char_gap <= pwdata[mck_pkg::TICK_W-1:0];
                mck_pkg::REG_WORD_GAP: cfg_reg.word_gap <= pwdata[mck_pkg::TICK_W-1:0];
                default: ;  // unmapped: write dropped
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        case (reg_idx)
            mck_pkg::REG_DOT:      prdata[mck_pkg::TICK_W-1:0] = cfg_reg.dot;
            mck_pkg::REG_DASH:     prdata[mck_pkg::TICK_W-1:0] = cfg_reg.dash;
            mck_pkg::REG_ELEM_GAP: prdata[mck_pkg::TICK_W-1:0] = cfg_reg.elem_gap;
            mck_pkg::REG_CHAR_GAP: prdata[mck_pkg::TICK_W-1:0] = cfg_reg.char_gap;
            mck_pkg::REG_WORD_GAP: prdata[mck_pkg::TICK_W-1:0] = cfg_reg.word_gap;
            default:               prdata = '0;
        endcase
    end

    // ---- front: classify the character ----
    mck_front u_front (
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .q_full   (q_full),
        .q_wr     (q_wr),
        .q_wdata  (q_wdata)
    );

    // ---- descriptor queue ----
    mck_queue u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr      (q_wr),
        .wdata   (q_wdata),
        .full    (q_full),
        .rd      (q_rd),
        .rvalid  (q_valid),
        .rdata   (q_rdata)
    );

    // ---- back: segment sequencer and output register ----
    mck_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg_reg),
        .q_valid  (q_valid),
        .q_data   (q_rdata),
        .q_rd     (q_rd),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

endmodule

### hw/rtl/mck_front.sv
module mck_front (
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [mck_pkg::CODE_W-1:0]  s_tdata,
    input  logic                        s_tlast,
    input  logic                        q_full,
    output logic                        q_wr,
    output mck_pkg::desc_t              q_wdata
);

    // glyph table lookup, straight into the queue
    assign s_tready = !q_full;
    assign q_wr     = s_tvalid && !q_full;
    assign q_wdata  = mck_pkg::classify(s_tdata, s_tlast);

endmodule

### hw/rtl/mck_queue.sv
module mck_queue (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            wr,
    input  mck_pkg::desc_t  wdata,
    output logic            full,
    input  logic            rd,
    output logic            rvalid,
    output mck_pkg::desc_t  rdata
);

    mck_pkg::desc_t                  mem_reg [mck_pkg::QUEUE_DEPTH];
    logic [mck_pkg::QPTR_W-1:0]      wptr_reg, wptr_next;
    logic [mck_pkg::QPTR_W-1:0]      rptr_reg, rptr_next;
    logic [mck_pkg::QCNT_W-1:0]      cnt_reg, cnt_next;

    localparam logic [mck_pkg::QPTR_W-1:0] LAST_PTR = mck_pkg::QPTR_W'(mck_pkg::QUEUE_DEPTH - 1);
    localparam logic [mck_pkg::QCNT_W-1:0] FULL_CNT = mck_pkg::QCNT_W'(mck_pkg::QUEUE_DEPTH);

    assign full   = (cnt_reg == FULL_CNT);
    assign rvalid = (cnt_reg != '0);
    assign rdata  = mem_reg[rptr_reg];

    always_comb begin
        wptr_next = wptr_reg;
        rptr_next = rptr_reg;
        cnt_next  = cnt_reg;
        if (wr) begin
            wptr_next = (wptr_reg == LAST_PTR) ? '0 : wptr_reg + 1'b1;
        end
        if (rd) begin
            rptr_next = (rptr_reg == LAST_PTR) ? '0 : rptr_reg + 1'b1;
        end
        if (wr && !rd) begin
            cnt_next = cnt_reg + 1'b1;
        end else if (rd && !wr) begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg  <= '0;
        end else begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr) begin
            mem_reg[wptr_reg] <= wdata;
        end
    end

endmodule

### hw/rtl/mck_back.sv
module mck_back (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  mck_pkg::cfg_t                 cfg,
    input  logic                          q_valid,
    input  mck_pkg::desc_t                q_data,
    output logic                          q_rd,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [mck_pkg::M_TDATA_W-1:0] m_tdata,
    output logic                          m_tlast,
    output logic                          m_tuser
);

    mck_pkg::desc_t                     cur_reg;
    logic                               cur_valid_reg, cur_valid_next;
    logic [mck_pkg::ELEM_IDX_W-1:0]     idx_reg, idx_next;
    logic                               gap_reg, gap_next;

    logic                               out_valid_reg, out_valid_next;
    logic                               out_led_reg;
    logic [mck_pkg::TICK_W-1:0]         out_dur_reg;
    logic                               out_last_reg;
    logic                               out_unk_reg;

    logic                               emit, final_elem, seg_last;
    logic                               seg_led;
    logic [mck_pkg::TICK_W-1:0]         seg_dur;

    assign emit       = cur_valid_reg && (!out_valid_reg || m_tready);
    assign final_elem = (idx_reg == cur_reg.count - 1'b1);
    assign seg_last   = cur_reg.unknown || (gap_reg && final_elem);
    assign q_rd       = q_valid && (!cur_valid_reg || (emit && seg_last));

    always_comb begin
        seg_led = 1'b0;
        seg_dur = '0;
        if (cur_reg.unknown) begin
            seg_led = 1'b0;
            seg_dur = '0;
        end else if (!gap_reg) begin
            seg_led = 1'b1;
            seg_dur = cur_reg.shape[idx_reg] ? cfg.dash : cfg.dot;
        end else if (final_elem) begin
            seg_dur = cur_reg.word_end ? cfg.word_gap : cfg.char_gap;
        end else begin
            seg_dur = cfg.elem_gap;
        end
    end

    always_comb begin
        cur_valid_next = cur_valid_reg;
        idx_next       = idx_reg;
        gap_next       = gap_reg;
        out_valid_next = out_valid_reg;
        if (m_tready) begin
            out_valid_next = 1'b0;
        end
        if (emit) begin
            out_valid_next = 1'b1;
            if (seg_last) begin
                cur_valid_next = 1'b0;
            end else if (gap_reg) begin
                idx_next = idx_reg + 1'b1;
                gap_next = 1'b0;
            end else begin
                gap_next = 1'b1;
            end
        end
        if (q_rd) begin
            cur_valid_next = 1'b1;
            idx_next       = '0;
            gap_next       = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_valid_reg <= 1'b0;
            idx_reg       <= '0;
            gap_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            cur_valid_reg <= cur_valid_next;
            idx_reg       <= idx_next;
            gap_reg       <= gap_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (q_rd) begin
            cur_reg <= q_data;
        end
        if (emit) begin
            out_led_reg  <= seg_led;
            out_dur_reg  <= seg_dur;
            out_last_reg <= seg_last;
            out_unk_reg  <= cur_reg.unknown;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(mck_pkg::M_TDATA_W - mck_pkg::TICK_W - 1){1'b0}},
                       out_dur_reg, out_led_reg};
    assign m_tlast  = out_last_reg;
    assign m_tuser  = out_unk_reg;

endmodule

### hw/rtl/mck_checker.sv
module mck_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [mck_pkg::M_TDATA_W-1:0] m_tdata,
    input logic                          m_tlast,
    input logic                          m_tuser
);

    // unknown character is a single, final segment
    a_unk_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tlast)
        else $error("unknown segment without tlast");

    // unknown segment is off and zero length
    a_unk_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> (m_tdata[mck_pkg::TICK_W:0] == '0))
        else $error("unknown segment not empty");

    // a mark is never the closing segment
    a_mark_not_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[0] |-> !m_tlast && !m_tuser)
        else $error("mark segment flagged last or unknown");

    // segment held while stalled
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("segment changed under stall");

endmodule

bind morse_code_keyer_timing mck_checker u_mck_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
);
